### hw/rtl/sha_pkg.sv
// SHA-256 hasher package: payload structs, round constants, initial hash values.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  localparam logic KindByte = 1'b0;
  localparam logic KindEnd  = 1'b1;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h;
    unique case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

endpackage

### hw/rtl/sha_round.sv
// One SHA-256 round on registered working variables a..h.
// Depends on sha_pkg for nothing but style; pure combinational round logic.
`timescale 1ns / 1ps
module sha_round
  import sha_pkg::*;
(
  input  logic [7:0][31:0] v_i,
  input  logic [31:0]      k_i,
  input  logic [31:0]      w_i,
  output logic [7:0][31:0] v_o
);

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] a, e, t1, t2;

  always_comb begin
    a  = v_i[0];
    e  = v_i[4];
    t1 = v_i[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
         + ((e & v_i[5]) ^ (~e & v_i[6])) + k_i + w_i;
    t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
         + ((a & v_i[1]) ^ (a & v_i[2]) ^ (v_i[1] & v_i[2]));
    v_o[7] = v_i[6];
    v_o[6] = v_i[5];
    v_o[5] = v_i[4];
    v_o[4] = v_i[3] + t1;
    v_o[3] = v_i[2];
    v_o[2] = v_i[1];
    v_o[1] = v_i[0];
    v_o[0] = t1 + t2;
  end

endmodule

### hw/rtl/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher top level: byte packing, block memory, sequencer.
// Depends on sha_pkg and sha_round.
`timescale 1ns / 1ps
// A message byte is taken while idle; the 64th of a block starts a compression,
// during which no transaction is accepted. The block words live in a 16-entry
// memory with a registered read. Rounds 0..15 use the word read from memory.
// Rounds 16..63 read w[i-2], w[i-15], w[i-7] and w[i-16] one per cycle, form
// the new schedule word into a register, then run the round and write the word
// back. A load step before the rounds and an add step after them complete the
// compression. An end-of-message transaction writes the pad word, clears the
// rest of the block one word per cycle, writes the two length words and runs
// one compression, or two when the pad byte lands at byte 56 or later of the
// block. It then presents the eight digest words, one per accepted output
// transaction.
module sha256_byte_stream_hasher
  import sha_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sha_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sha_out_t out_data_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StZero  = 4'd1;
  localparam logic [3:0] StLenHi = 4'd2;
  localparam logic [3:0] StLenLo = 4'd3;
  localparam logic [3:0] StInit  = 4'd4;
  localparam logic [3:0] StRd2   = 4'd5;
  localparam logic [3:0] StRd15  = 4'd6;
  localparam logic [3:0] StRd7   = 4'd7;
  localparam logic [3:0] StRdW   = 4'd8;
  localparam logic [3:0] StRound = 4'd9;
  localparam logic [3:0] StAdd   = 4'd10;
  localparam logic [3:0] StOut   = 4'd11;

  logic [3:0]  state_q, state_d;
  logic [60:0] count_q, count_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [3:0]  zw_q, zw_d;
  logic        final_q, final_d;
  logic        two_q, two_d;
  logic [2:0]  oidx_q, oidx_d;
  logic [31:0] pack_q, pack_d;

  logic [7:0][31:0] hash_q, hash_d;
  logic [7:0][31:0] v_q, v_d, v_next;
  logic [31:0] x2_q, x2_d, x15_q, x15_d, x7_q, x7_d;
  logic [31:0] wnew_q, wnew_d;

  logic [31:0] mem [16];
  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] wsched, wcur;
  logic [5:0]  pos;
  logic [63:0] bits;
  logic [31:0] padded;
  logic        in_fire, out_fire;

  assign pos   = count_q[5:0];
  assign bits  = {count_q, 3'b000};
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_data_o.digest_word = hash_q[oidx_q];
  assign out_data_o.word_index  = oidx_q;
  assign out_data_o.last_word   = (oidx_q == 3'd7);

  always_comb begin
    wsched = (ror(x2_q, 17) ^ ror(x2_q, 19) ^ (x2_q >> 10)) + x7_q
             + (ror(x15_q, 7) ^ ror(x15_q, 18) ^ (x15_q >> 3)) + rdata_q;
    wcur = (rnd_q >= 6'd16) ? wnew_q : rdata_q;
  end

  sha_round u_round (
    .v_i (v_q),
    .k_i (round_k(rnd_q)),
    .w_i (wcur),
    .v_o (v_next)
  );

  always_comb begin
    unique case (pos[1:0])
      2'd0: padded = {PadByte, 24'd0};
      2'd1: padded = {pack_q[31:24], PadByte, 16'd0};
      2'd2: padded = {pack_q[31:16], PadByte, 8'd0};
      default: padded = {pack_q[31:8], PadByte};
    endcase
  end

  always_comb begin
    state_d = state_q; count_d = count_q; rnd_d = rnd_q; zw_d = zw_q;
    final_d = final_q; two_d = two_q; oidx_d = oidx_q; pack_d = pack_q;
    hash_d = hash_q; v_d = v_q; x2_d = x2_q; x15_d = x15_q; x7_d = x7_q;
    wnew_d = wnew_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (in_data_i.kind == KindByte) begin
            unique case (pos[1:0])
              2'd0: pack_d = {in_data_i.data_byte, 24'd0};
              2'd1: pack_d = {pack_q[31:24], in_data_i.data_byte, 16'd0};
              2'd2: pack_d = {pack_q[31:16], in_data_i.data_byte, 8'd0};
              default: pack_d = {pack_q[31:8], in_data_i.data_byte};
            endcase
            count_d = count_q + 61'd1;
            if (pos[1:0] == 2'd3) begin
              we = 1'b1; waddr = pos[5:2]; wdata = pack_d;
            end
            if (pos == 6'd63) begin
              final_d = 1'b0; state_d = StInit;
            end
          end else begin
            we = 1'b1; waddr = pos[5:2]; wdata = padded;
            two_d = (pos >= LenPos);
            final_d = 1'b1;
            zw_d = pos[5:2] + 4'd1;
            if (pos[5:2] == 4'd15) begin
              state_d = StInit;
            end else begin
              state_d = StZero;
            end
          end
        end
      end
      StZero: begin
        // clear words after the pad byte, skipping the length words when they fit
        we = 1'b1; waddr = zw_q; wdata = '0;
        zw_d = zw_q + 4'd1;
        if (!two_q && zw_q == 4'd13) begin
          state_d = StLenHi;
        end else if (zw_q == 4'd15) begin
          state_d = two_q ? StInit : StLenHi;
        end
      end
      StLenHi: begin
        we = 1'b1; waddr = 4'd14; wdata = bits[63:32];
        state_d = StLenLo;
      end
      StLenLo: begin
        we = 1'b1; waddr = 4'd15; wdata = bits[31:0];
        state_d = StInit;
      end
      StInit: begin
        v_d = hash_q; rnd_d = '0;
        raddr = 4'd0;
        state_d = StRound;
      end
      StRd2: begin
        x2_d = rdata_q;
        raddr = rnd_q[3:0] - 4'd15;
        state_d = StRd15;
      end
      StRd15: begin
        x15_d = rdata_q;
        raddr = rnd_q[3:0] - 4'd7;
        state_d = StRd7;
      end
      StRd7: begin
        x7_d = rdata_q;
        raddr = rnd_q[3:0];
        state_d = StRdW;
      end
      StRdW: begin
        wnew_d = wsched;
        state_d = StRound;
      end
      StRound: begin
        v_d = v_next;
        if (rnd_q >= 6'd16) begin
          we = 1'b1; waddr = rnd_q[3:0]; wdata = wnew_q;
        end
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = StAdd;
        end else if (rnd_d >= 6'd16) begin
          raddr = rnd_d[3:0] - 4'd2;
          state_d = StRd2;
        end else begin
          raddr = rnd_d[3:0];
        end
      end
      StAdd: begin
        for (int j = 0; j < 8; j++) begin
          hash_d[j] = hash_q[j] + v_q[j];
        end
        if (!final_q) begin
          state_d = StIdle;
        end else if (two_q) begin
          two_d = 1'b0; zw_d = 4'd0; state_d = StZero;
        end else begin
          oidx_d = '0; state_d = StOut;
        end
      end
      StOut: begin
        if (out_fire) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            for (int j = 0; j < 8; j++) begin
              hash_d[j] = init_hash(3'(j));
            end
            count_d = '0;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      rnd_q   <= '0;
      zw_q    <= '0;
      final_q <= 1'b0;
      two_q   <= 1'b0;
      oidx_q  <= '0;
      for (int j = 0; j < 8; j++) begin
        hash_q[j] <= init_hash(3'(j));
      end
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rnd_q   <= rnd_d;
      zw_q    <= zw_d;
      final_q <= final_d;
      two_q   <= two_d;
      oidx_q  <= oidx_d;
      hash_q  <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pack_q <= pack_d;
    v_q    <= v_d;
    x2_q   <= x2_d;
    x15_q  <= x15_d;
    x7_q   <= x7_d;
    wnew_q <= wnew_d;
  end

endmodule

### hw/rtl/sha_checker.sv
// Port-level checker for the SHA-256 hasher, bound to the top level.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_checker
  import sha_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input sha_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input sha_out_t out_data_o
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input taken while digest pending");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_word == (out_data_o.word_index == 3'd7)))
    else $error("last flag mismatch");

  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_data_o.last_word) |=>
      (out_valid_o && out_data_o.word_index == $past(out_data_o.word_index) + 3'd1))
    else $error("digest index did not advance");

  a_end_no_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.kind == KindEnd) |=> !in_ready_o)
    else $error("end of message did not stall input");

endmodule

bind sha256_byte_stream_hasher sha_checker u_sha_checker (.*);
